/* design/apdf_pkg.sv */
// Package for the addressed packet deframer: states, codes and the CRC-16 step.
`default_nettype none

package apdf_pkg;

  typedef enum logic [8:0] {
    S_START   = 9'b0_0000_0001,
    S_ADDR_HI = 9'b0_0000_0010,
    S_ADDR_LO = 9'b0_0000_0100,
    S_LEN     = 9'b0_0000_1000,
    S_CMD     = 9'b0_0001_0000,
    S_DATA    = 9'b0_0010_0000,
    S_CRC_HI  = 9'b0_0100_0000,
    S_CRC_LO  = 9'b0_1000_0000,
    S_REPLAY  = 9'b1_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_CRC = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_OTHER   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_OWN_ADDR_HI = 2'd0,
    REG_OWN_ADDR_LO = 2'd1,
    REG_START_MARK  = 2'd2,
    REG_PAYLOAD_CMD = 2'd3
  } cfg_reg_e;

  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPoly        = 16'h1021;
  localparam logic [7:0]  PayloadCmdInit = 8'hA4;

  // CRC-16 CCITT, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/apdf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module apdf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/addressed_packet_deframer_crc16.sv */
// Output: a result is registered at the edge that takes the byte completing a packet;
// a replayed payload byte passes the RAM read register and then the result register.
// Throughput: one received byte per cycle while the result register is free; the input
// is held off in a replay, which reads a byte only after the last read has landed.
// Reset: async active low; clears FSM, CRC, counters and config registers;
// the payload RAM is not cleared (every replayed byte is written first).
`default_nettype none

module addressed_packet_deframer_crc16 #(
  parameter int PAYLOAD_MAX = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [1:0] status_o,
  output logic            addressed_to_us_o,
  output logic      [7:0] command_code_o,
  output logic      [6:0] frame_len_o,
  output logic      [7:0] data_byte_o,
  output logic            data_present_o,
  output logic            last_of_packet_o
);

  localparam int AddrW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam logic [7:0] MaxLen = 8'(PAYLOAD_MAX);
  localparam logic [6:0] SatLen = 7'((PAYLOAD_MAX > 127) ? 127 : PAYLOAD_MAX);

  // config registers
  logic [7:0] own_hi_q, own_lo_q, start_mark_q, pay_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_hi_q     <= 8'h00;
      own_lo_q     <= 8'h00;
      start_mark_q <= 8'h00;
      pay_cmd_q    <= apdf_pkg::PayloadCmdInit;
    end else if (cfg_we_i) begin
      unique case (apdf_pkg::cfg_reg_e'(cfg_idx_i))
        apdf_pkg::REG_OWN_ADDR_HI: own_hi_q     <= cfg_wdata_i;
        apdf_pkg::REG_OWN_ADDR_LO: own_lo_q     <= cfg_wdata_i;
        apdf_pkg::REG_START_MARK:  start_mark_q <= cfg_wdata_i;
        apdf_pkg::REG_PAYLOAD_CMD: pay_cmd_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  apdf_pkg::state_e state_q, state_d;
  logic [7:0]  net_hi_q, net_hi_d, net_lo_q, net_lo_d;
  logic [7:0]  len_q, len_d, cmd_q, cmd_d, crc_hi_q, crc_hi_d;
  logic [7:0]  wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [15:0] crc_q, crc_d;
  logic        rd_pend_q, rd_pend_d, pend_last_q, pend_last_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic        ours_q, ours_d, present_q, present_d, last_q, last_d;
  logic [7:0]  ocmd_q, ocmd_d, data_q, data_d;
  logic [6:0]  olen_q, olen_d;

  logic        out_free, acc, ours, rd_issue, ram_we;
  logic [15:0] crc_next;
  logic [7:0]  wr_idx_inc, ram_rdata;

  assign out_free   = !out_valid_q || out_ready_i;
  assign rx_ready_o = (state_q != apdf_pkg::S_REPLAY) && out_free;
  assign acc        = rx_valid_i && rx_ready_o;
  assign ours       = (net_hi_q == own_hi_q) && (net_lo_q == own_lo_q);
  assign crc_next   = apdf_pkg::crc_byte(crc_q, rx_byte_i);
  assign wr_idx_inc = wr_idx_q + 8'd1;
  assign ram_we     = acc && (state_q == apdf_pkg::S_DATA);
  // one read in flight at a time, only when the result register is free
  assign rd_issue   = (state_q == apdf_pkg::S_REPLAY) && !rd_pend_q && out_free;

  // writes happen only in the data phase, reads only in replay: no overlap
  apdf_ram #(.Width(8), .Depth(PAYLOAD_MAX)) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    net_hi_d    = net_hi_q;
    net_lo_d    = net_lo_q;
    len_d       = len_q;
    cmd_d       = cmd_q;
    crc_hi_d    = crc_hi_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    crc_d       = crc_q;
    rd_pend_d   = rd_issue;
    pend_last_d = pend_last_q;

    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    ours_d      = ours_q;
    ocmd_d      = ocmd_q;
    olen_d      = olen_q;
    data_d      = data_q;
    present_d   = present_q;
    last_d      = last_q;

    if (acc) begin
      unique case (state_q)
        apdf_pkg::S_START: begin
          if (rx_byte_i == start_mark_q) begin
            crc_d   = apdf_pkg::crc_byte(apdf_pkg::CrcInit, rx_byte_i);
            state_d = apdf_pkg::S_ADDR_HI;
          end
        end
        apdf_pkg::S_ADDR_HI: begin
          net_hi_d = rx_byte_i;
          crc_d    = crc_next;
          state_d  = apdf_pkg::S_ADDR_LO;
        end
        apdf_pkg::S_ADDR_LO: begin
          net_lo_d = rx_byte_i;
          crc_d    = crc_next;
          state_d  = apdf_pkg::S_LEN;
        end
        apdf_pkg::S_LEN: begin
          if (rx_byte_i > MaxLen) begin
            len_d       = {1'b0, SatLen};
            out_valid_d = 1'b1;
            status_d    = apdf_pkg::ST_BAD_LEN;
            ours_d      = ours;
            ocmd_d      = 8'h00;
            olen_d      = SatLen;
            data_d      = 8'h00;
            present_d   = 1'b0;
            last_d      = 1'b1;
            state_d     = apdf_pkg::S_START;
          end else begin
            len_d    = rx_byte_i;
            wr_idx_d = 8'h00;
            crc_d    = crc_next;
            state_d  = apdf_pkg::S_CMD;
          end
        end
        apdf_pkg::S_CMD: begin
          cmd_d = rx_byte_i;
          crc_d = crc_next;
          if (rx_byte_i == pay_cmd_q && len_q != 8'h00) begin
            state_d = apdf_pkg::S_DATA;
          end else begin
            state_d = apdf_pkg::S_CRC_HI;
          end
        end
        apdf_pkg::S_DATA: begin
          crc_d    = crc_next;
          wr_idx_d = wr_idx_inc;
          if (wr_idx_inc >= len_q) begin
            state_d = apdf_pkg::S_CRC_HI;
          end
        end
        apdf_pkg::S_CRC_HI: begin
          crc_hi_d = rx_byte_i;
          state_d  = apdf_pkg::S_CRC_LO;
        end
        apdf_pkg::S_CRC_LO: begin
          ours_d    = ours;
          ocmd_d    = cmd_q;
          olen_d    = len_q[6:0];
          data_d    = 8'h00;
          present_d = 1'b0;
          last_d    = 1'b1;
          state_d   = apdf_pkg::S_START;
          if ({crc_hi_q, rx_byte_i} != crc_q) begin
            out_valid_d = 1'b1;
            status_d    = apdf_pkg::ST_BAD_CRC;
          end else if (!ours) begin
            out_valid_d = 1'b1;
            status_d    = apdf_pkg::ST_OTHER;
          end else if (cmd_q == pay_cmd_q && len_q != 8'h00) begin
            rd_idx_d = 8'h00;
            state_d  = apdf_pkg::S_REPLAY;
          end else begin
            out_valid_d = 1'b1;
            status_d    = apdf_pkg::ST_GOOD;
          end
        end
        default: ;
      endcase
    end

    if (rd_issue) begin
      rd_idx_d    = rd_idx_q + 8'd1;
      pend_last_d = (rd_idx_q + 8'd1) == len_q;
    end

    // read data lands: result register is known free here
    if (rd_pend_q) begin
      out_valid_d = 1'b1;
      status_d    = apdf_pkg::ST_GOOD;
      ours_d      = 1'b1;
      ocmd_d      = cmd_q;
      olen_d      = len_q[6:0];
      data_d      = ram_rdata;
      present_d   = 1'b1;
      last_d      = pend_last_q;
      if (pend_last_q) begin
        state_d = apdf_pkg::S_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apdf_pkg::S_START;
      net_hi_q    <= 8'h00;
      net_lo_q    <= 8'h00;
      len_q       <= 8'h00;
      cmd_q       <= 8'h00;
      crc_hi_q    <= 8'h00;
      wr_idx_q    <= 8'h00;
      rd_idx_q    <= 8'h00;
      crc_q       <= apdf_pkg::CrcInit;
      rd_pend_q   <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      net_hi_q    <= net_hi_d;
      net_lo_q    <= net_lo_d;
      len_q       <= len_d;
      cmd_q       <= cmd_d;
      crc_hi_q    <= crc_hi_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      crc_q       <= crc_d;
      rd_pend_q   <= rd_pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    ours_q    <= ours_d;
    ocmd_q    <= ocmd_d;
    olen_q    <= olen_d;
    data_q    <= data_d;
    present_q <= present_d;
    last_q    <= last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign addressed_to_us_o = ours_q;
  assign command_code_o    = ocmd_q;
  assign frame_len_o       = olen_q;
  assign data_byte_o       = data_q;
  assign data_present_o    = present_q;
  assign last_of_packet_o  = last_q;

endmodule

`default_nettype wire
